/* sv/bpi_pkg.sv */
// ----------------------------------------------------------------------------
// Bilinear pixel interpolator package
// Shared constants, register indexes and the pipeline enable bundle.
// ----------------------------------------------------------------------------
package bpi_pkg;

    localparam int LANES      = 8;
    localparam int FRAC_BITS  = 8;
    localparam int PIX_W      = 8;
    localparam int BUS_W      = 64;
    localparam int COL_W      = 12;
    localparam int ROW_W      = 12;
    localparam int STEP_W     = 16;
    localparam int START_W    = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int ACC_W      = 2 * PIX_W;

    localparam logic [FRAC_BITS-1:0] WEIGHT_ONE = 8'd255;
    localparam logic [PIX_W-1:0]     PIX_MAX    = 8'd255;

    localparam logic [STEP_W-1:0]  X_STEP_RST  = 16'd256;
    localparam logic [STEP_W-1:0]  Y_STEP_RST  = 16'd256;
    localparam logic [START_W-1:0] Y_START_RST = 24'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_STEP  = 2'd0,
        REG_Y_STEP  = 2'd1,
        REG_Y_START = 2'd2
    } t_reg_idx;

    // Per-stage load enables produced by the pipeline control.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_pipe_en;

endpackage

/* sv/bilinear_pixel_interpolator_top.sv */
// ----------------------------------------------------------------------------
// Bilinear pixel interpolator
// Eight 8-bit lanes of 8.8 fixed-point bilinear blending per request.
// ----------------------------------------------------------------------------
//   Channel   Handshake                      Payload
//   input     i_in_valid / o_in_ready        column, row, four neighbour words
//   output    o_out_valid / i_out_ready      output_pixels
//   config    i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// One request enters per cycle while o_in_ready is high. Four register stages
// (fraction, horizontal blend, vertical weighting, sum) lie between the edge
// that takes the request and o_out_valid.
// Reset clears the stage valid bits and loads the default step and start values.
// A stall on the output holds the last stage; empty stages upstream still
// fill, so no request is lost or repeated.
// ----------------------------------------------------------------------------
module bilinear_pixel_interpolator_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bpi_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bpi_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [bpi_pkg::COL_W-1:0]        i_out_column,
    input  logic [bpi_pkg::ROW_W-1:0]        i_out_row,
    input  logic [bpi_pkg::BUS_W-1:0]        i_top_left_pixels,
    input  logic [bpi_pkg::BUS_W-1:0]        i_top_right_pixels,
    input  logic [bpi_pkg::BUS_W-1:0]        i_bottom_left_pixels,
    input  logic [bpi_pkg::BUS_W-1:0]        i_bottom_right_pixels,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [bpi_pkg::BUS_W-1:0]        o_output_pixels
);
    import bpi_pkg::*;

    logic [STEP_W-1:0]    x_step;
    logic [STEP_W-1:0]    y_step;
    logic [START_W-1:0]   y_start;
    t_pipe_en             en;

    logic [2*FRAC_BITS-1:0] fy_prod;
    logic [FRAC_BITS-1:0]   n_fy;
    logic [FRAC_BITS-1:0]   r_fy;
    logic [BUS_W-1:0]       r_tl, r_tr, r_bl, r_br;

    bpi_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_x_step    (x_step),
        .o_y_step    (y_step),
        .o_y_start   (y_start)
    );

    bpi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_en        (en)
    );

    // Only the fraction of each position is used, and the low bits of a
    // sum or product depend only on the low bits of its operands.
    assign fy_prod = i_out_row[FRAC_BITS-1:0] * y_step[FRAC_BITS-1:0];
    assign n_fy    = y_start[FRAC_BITS-1:0] + fy_prod[FRAC_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (en.s1) begin
            r_fy <= n_fy;
            r_tl <= i_top_left_pixels;
            r_tr <= i_top_right_pixels;
            r_bl <= i_bottom_left_pixels;
            r_br <= i_bottom_right_pixels;
        end
    end

    for (genvar k = 0; k < BUS_W / PIX_W; k++) begin : g_lane
        if (k < LANES) begin : g_used
            logic [FRAC_BITS-1:0]   col_k;
            logic [2*FRAC_BITS-1:0] fx_prod;
            logic [FRAC_BITS-1:0]   r_fx;
            logic [PIX_W-1:0]       pix;

            assign col_k   = i_out_column[FRAC_BITS-1:0] + FRAC_BITS'(k);
            assign fx_prod = col_k * x_step[FRAC_BITS-1:0];

            always_ff @(posedge i_clk) begin
                if (en.s1) begin
                    r_fx <= fx_prod[FRAC_BITS-1:0];
                end
            end

            bpi_lane u_lane (
                .i_clk (i_clk),
                .i_en  (en),
                .i_tl  (r_tl[k*PIX_W +: PIX_W]),
                .i_tr  (r_tr[k*PIX_W +: PIX_W]),
                .i_bl  (r_bl[k*PIX_W +: PIX_W]),
                .i_br  (r_br[k*PIX_W +: PIX_W]),
                .i_fx  (r_fx),
                .i_fy  (r_fy),
                .o_pix (pix)
            );

            assign o_output_pixels[k*PIX_W +: PIX_W] = pix;
        end else begin : g_unused
            assign o_output_pixels[k*PIX_W +: PIX_W] = '0;
        end
    end

endmodule

/* sv/bpi_cfg.sv */
// ----------------------------------------------------------------------------
// Bilinear interpolator configuration registers
// Holds the horizontal step, vertical step and vertical start position.
// ----------------------------------------------------------------------------
module bpi_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bpi_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bpi_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic [bpi_pkg::STEP_W-1:0]       o_x_step,
    output logic [bpi_pkg::STEP_W-1:0]       o_y_step,
    output logic [bpi_pkg::START_W-1:0]      o_y_start
);
    import bpi_pkg::*;

    logic [STEP_W-1:0]  r_x_step;
    logic [STEP_W-1:0]  r_y_step;
    logic [START_W-1:0] r_y_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_step  <= X_STEP_RST;
            r_y_step  <= Y_STEP_RST;
            r_y_start <= Y_START_RST;
        end else if (i_cfg_valid) begin
            // Indexes past the register list are dropped.
            unique case (t_reg_idx'(i_cfg_index))
                REG_X_STEP:  r_x_step  <= i_cfg_data[STEP_W-1:0];
                REG_Y_STEP:  r_y_step  <= i_cfg_data[STEP_W-1:0];
                REG_Y_START: r_y_start <= i_cfg_data[START_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_x_step    = r_x_step;
    assign o_y_step    = r_y_step;
    assign o_y_start   = r_y_start;

endmodule

/* sv/bpi_ctrl.sv */
// ----------------------------------------------------------------------------
// Bilinear interpolator pipeline control
// Valid bits of the four stages and the back-pressure chain between them.
// ----------------------------------------------------------------------------
module bpi_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output bpi_pkg::t_pipe_en o_en
);
    import bpi_pkg::*;

    logic r_v1, r_v2, r_v3, r_v4;
    logic adv1, adv2, adv3, adv4;

    // A stage may load when it is empty or its content moves on this cycle.
    assign adv4 = !r_v4 || i_out_ready;
    assign adv3 = !r_v3 || adv4;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_in_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
            if (adv4) begin
                r_v4 <= r_v3;
            end
        end
    end

    assign o_in_ready  = adv1;
    assign o_out_valid = r_v4;
    assign o_en.s1     = adv1;
    assign o_en.s2     = adv2;
    assign o_en.s3     = adv3;
    assign o_en.s4     = adv4;

endmodule

/* sv/bpi_lane.sv */
// ----------------------------------------------------------------------------
// Bilinear interpolator lane
// Stages two to four of one lane: horizontal blend, vertical weighting, sum.
// ----------------------------------------------------------------------------
module bpi_lane (
    input  logic                          i_clk,
    input  bpi_pkg::t_pipe_en             i_en,
    input  logic [bpi_pkg::PIX_W-1:0]     i_tl,
    input  logic [bpi_pkg::PIX_W-1:0]     i_tr,
    input  logic [bpi_pkg::PIX_W-1:0]     i_bl,
    input  logic [bpi_pkg::PIX_W-1:0]     i_br,
    input  logic [bpi_pkg::FRAC_BITS-1:0] i_fx,
    input  logic [bpi_pkg::FRAC_BITS-1:0] i_fy,
    output logic [bpi_pkg::PIX_W-1:0]     o_pix
);
    import bpi_pkg::*;

    logic [FRAC_BITS-1:0]       fx1;
    logic [ACC_W-1:0]           n_a, n_b;
    logic [ACC_W-1:0]           r_a, r_b;
    logic [FRAC_BITS-1:0]       r_fy2;
    logic [ACC_W+FRAC_BITS-1:0] top_prod, bot_prod;
    logic [PIX_W-1:0]           r_top, r_bot;
    logic [PIX_W:0]             sum;
    logic [PIX_W-1:0]           r_pix;

    // The two weights sum to 255, so each blend fits in 16 bits.
    assign fx1 = WEIGHT_ONE - i_fx;
    assign n_a = ACC_W'(i_tl) * ACC_W'(fx1) + ACC_W'(i_tr) * ACC_W'(i_fx);
    assign n_b = ACC_W'(i_bl) * ACC_W'(fx1) + ACC_W'(i_br) * ACC_W'(i_fx);

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_a   <= n_a;
            r_b   <= n_b;
            r_fy2 <= i_fy;
        end
    end

    assign top_prod = (ACC_W+FRAC_BITS)'(r_a) * (ACC_W+FRAC_BITS)'(WEIGHT_ONE - r_fy2);
    assign bot_prod = (ACC_W+FRAC_BITS)'(r_b) * (ACC_W+FRAC_BITS)'(r_fy2);

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_top <= top_prod[ACC_W+FRAC_BITS-1:ACC_W];
            r_bot <= bot_prod[ACC_W+FRAC_BITS-1:ACC_W];
        end
    end

    assign sum = {1'b0, r_top} + {1'b0, r_bot};

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_pix <= sum[PIX_W] ? PIX_MAX : sum[PIX_W-1:0];
        end
    end

    assign o_pix = r_pix;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear pixel interpolator testbench
// Drives pixel requests and register writes into the interpolator, predicts
// each eight-lane result in place and compares it with the block's output
// while both sides of the stream stall at random.
// ----------------------------------------------------------------------------
module tb_top;

    import bpi_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int                   HOLD_OFF_CYCLES = 200;
    localparam int                   SETTLE_CYCLES   = 8;
    localparam int                   STALL_LIMIT     = 4000;
    localparam int                   RANDOM_PHASES   = 8;
    localparam int                   PHASE_REQUESTS  = 138;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
        logic [BUS_W-1:0] top_left;
        logic [BUS_W-1:0] top_right;
        logic [BUS_W-1:0] bottom_left;
        logic [BUS_W-1:0] bottom_right;
    } t_pixel_request;

    typedef enum logic [2:0] {
        READY_ALWAYS,
        READY_HALF,
        READY_MOSTLY,
        READY_PERIODIC,
        READY_SPARSE
    } t_ready_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [COL_W-1:0]      i_out_column = '0;
    logic [ROW_W-1:0]      i_out_row = '0;
    logic [BUS_W-1:0]      i_top_left_pixels = '0;
    logic [BUS_W-1:0]      i_top_right_pixels = '0;
    logic [BUS_W-1:0]      i_bottom_left_pixels = '0;
    logic [BUS_W-1:0]      i_bottom_right_pixels = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [BUS_W-1:0]      o_output_pixels;

    // Local copy of the configuration registers, updated as each write is accepted.
    logic [STEP_W-1:0]     cfg_x_step  = X_STEP_RST;
    logic [STEP_W-1:0]     cfg_y_step  = Y_STEP_RST;
    logic [START_W-1:0]    cfg_y_start = Y_START_RST;

    logic [BUS_W-1:0]      pending_pixels [$];
    logic [BUS_W-1:0]      want_pixels;
    int                    error_count = 0;
    int                    stall_cycles = 0;

    int                    hold_off_seq = 0;
    int                    hold_off_seen = 0;
    int                    hold_off_left = 0;
    t_ready_mode           ready_mode = READY_ALWAYS;
    int                    ready_run = 0;
    logic [2:0]            ready_phase = '0;

    bilinear_pixel_interpolator_top u_top (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_out_column          (i_out_column),
        .i_out_row             (i_out_row),
        .i_top_left_pixels     (i_top_left_pixels),
        .i_top_right_pixels    (i_top_right_pixels),
        .i_bottom_left_pixels  (i_bottom_left_pixels),
        .i_bottom_right_pixels (i_bottom_right_pixels),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_output_pixels       (o_output_pixels)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Eight-lane bilinear blend with the register values currently in force.
    function automatic logic [BUS_W-1:0] interpolate_lanes(input t_pixel_request r);
        logic [31:0]      ypos;
        logic [31:0]      xpos;
        logic [7:0]       fyw;
        logic [7:0]       fy1;
        logic [7:0]       fxw;
        logic [7:0]       fx1;
        logic [15:0]      upper;
        logic [15:0]      lower;
        logic [31:0]      sum;
        logic [BUS_W-1:0] pixels;
        int               k;
        pixels = '0;
        ypos = 32'(cfg_y_start) + 32'(r.row) * 32'(cfg_y_step);
        fyw = ypos[7:0];
        fy1 = WEIGHT_ONE - fyw;
        for (k = 0; k < LANES; k++) begin
            xpos = (32'(r.column) + 32'(k)) * 32'(cfg_x_step);
            fxw = xpos[7:0];
            fx1 = WEIGHT_ONE - fxw;
            upper = 16'(r.top_left[8*k +: 8]) * 16'(fx1)
                  + 16'(r.top_right[8*k +: 8]) * 16'(fxw);
            lower = 16'(r.bottom_left[8*k +: 8]) * 16'(fx1)
                  + 16'(r.bottom_right[8*k +: 8]) * 16'(fxw);
            sum = ((32'(fy1) * 32'(upper)) >> 16) + ((32'(fyw) * 32'(lower)) >> 16);
            pixels[8*k +: 8] = (sum > 32'(PIX_MAX)) ? PIX_MAX : sum[7:0];
        end
        return pixels;
    endfunction

    function automatic logic [BUS_W-1:0] random_pixel_word();
        logic [BUS_W-1:0] word;
        logic [7:0]       level;
        int               k;
        case ($urandom_range(0, 3))
            0: begin
                for (k = 0; k < 8; k++) word[8*k +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            1: begin
                level = 8'($urandom_range(0, 255));
                word = {8{level}};
            end
            default: word = {$urandom, $urandom};
        endcase
        return word;
    endfunction

    function automatic logic [COL_W-1:0] random_coord();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return COL_W'($urandom_range(0, (1 << COL_W) - 1));
        endcase
    endfunction

    function automatic t_pixel_request random_request();
        t_pixel_request r;
        r.column       = random_coord();
        r.row          = random_coord();
        r.top_left     = random_pixel_word();
        r.top_right    = random_pixel_word();
        r.bottom_left  = random_pixel_word();
        r.bottom_right = random_pixel_word();
        // Flat patches: all four neighbours equal.
        if ($urandom_range(0, 7) == 0) begin
            r.top_right    = r.top_left;
            r.bottom_left  = r.top_left;
            r.bottom_right = r.top_left;
        end
        return r;
    endfunction

    // Data words for the step registers carry random upper bits that the block drops.
    function automatic logic [CFG_DATA_W-1:0] random_step_data();
        logic [STEP_W-1:0] step;
        case ($urandom_range(0, 5))
            0: step = 16'd1;
            1: step = 16'hFFFF;
            2: step = 16'd0;
            3: step = 16'h0100;
            default: step = STEP_W'($urandom_range(0, 16'hFFFF));
        endcase
        return {8'($urandom_range(0, 255)), step};
    endfunction

    // Valid is left high on acceptance so that back-to-back requests never drop it.
    task automatic send_request(input t_pixel_request r);
        i_in_valid            <= 1'b1;
        i_out_column          <= r.column;
        i_out_row             <= r.row;
        i_top_left_pixels     <= r.top_left;
        i_top_right_pixels    <= r.top_right;
        i_bottom_left_pixels  <= r.bottom_left;
        i_bottom_right_pixels <= r.bottom_right;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_pixels.push_back(interpolate_lanes(r));
    endtask

    task automatic send_pixels(input logic [COL_W-1:0] column, input logic [ROW_W-1:0] row,
                               input logic [BUS_W-1:0] tl, input logic [BUS_W-1:0] tr,
                               input logic [BUS_W-1:0] bl, input logic [BUS_W-1:0] br);
        t_pixel_request r;
        r = '{column, row, tl, tr, bl, br};
        send_request(r);
    endtask

    task automatic idle_sender(input int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_X_STEP:  cfg_x_step  = data[STEP_W-1:0];
            REG_Y_STEP:  cfg_y_step  = data[STEP_W-1:0];
            REG_Y_START: cfg_y_start = data[START_W-1:0];
            default: ;
        endcase
    endtask

    // Drains the pipeline, then writes all three registers back to back.
    task automatic configure(input logic [CFG_DATA_W-1:0] x_data,
                             input logic [CFG_DATA_W-1:0] y_data,
                             input logic [CFG_DATA_W-1:0] start_data,
                             input bit poke_unused);
        wait_for_results();
        write_register(REG_X_STEP, x_data);
        if (poke_unused) write_register(REG_UNUSED, CFG_DATA_W'($urandom));
        write_register(REG_Y_STEP, y_data);
        write_register(REG_Y_START, start_data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // With reset steps every fraction is zero, so only the top-left byte counts.
    task automatic test_reset_defaults();
        send_pixels('0, '0, '0, '0, '0, '0);
        send_pixels('0, '0, '1, '1, '1, '1);
        send_pixels('1, '1, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom});
        send_pixels(12'd77, 12'd300, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210,
                    64'h00FF00FF00FF00FF, 64'hFF00FF00FF00FF00);
    endtask

    task automatic test_fraction_extremes();
        // Unit steps with y_start 255: row zero puts all weight on the bottom row,
        // and columns 248..255 walk the horizontal fraction up to its maximum.
        configure(24'd1, 24'd1, 24'h0000FF, 1'b0);
        send_pixels(12'd248, 12'd0, '0, '0, 64'h0011223344556677, '1);
        send_pixels(12'd0, 12'd1, '1, '0, '0, '1);
        send_pixels(12'd120, 12'd129, '1, '1, '1, '1);
        configure(24'h00FFFF, 24'h00FFFF, 24'hFFFFFF, 1'b0);
        send_pixels('1, '1, '1, '1, '1, '1);
        send_pixels('0, '0, '1, '0, '1, '0);
        send_pixels(12'd2049, 12'd4000, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom});
        // Zero steps: every lane sees the same fractions.
        configure(24'd0, 24'd0, 24'h000080, 1'b0);
        send_pixels(12'd3, 12'd9, 64'h8040201008040201, '1, '0, 64'h0102040810204080);
        configure(24'h000080, 24'h000040, 24'h000000, 1'b0);
        send_pixels(12'd1, 12'd3, '1, '0, '0, '1);
        send_pixels('1, 12'd1, 64'hF0E0D0C0B0A09080, 64'h0F1F2F3F4F5F6F7F, '1, '0);
    endtask

    // The unused index must leave all registers alone, and step data above
    // bit 15 must be dropped.
    task automatic test_register_index();
        configure(24'hFF0003, 24'hABCD05, 24'h123456, 1'b1);
        send_pixels(12'd17, 12'd23, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom});
        wait_for_results();
        write_register(REG_UNUSED, 24'hFFFFFF);
        write_register(REG_UNUSED, 24'h000000);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        send_pixels(12'd17, 12'd23, '1, '0, '1, '0);
        send_pixels(12'd4000, 12'd5, 64'h5A5A5A5AA5A5A5A5, '1, '0, 64'h3C3C3C3CC3C3C3C3);
    endtask

    // The output stalls for a long stretch while requests keep coming, so the
    // pipeline fills and the input backs up.
    task automatic test_backpressure();
        int n;
        configure(24'h000133, 24'h0000C5, 24'h00A0FF, 1'b0);
        hold_off_seq <= hold_off_seq + 1;
        for (n = 0; n < 40; n++) send_request(random_request());
        wait_for_results();
    endtask

    task automatic test_random_phases();
        int phase;
        int sent;
        int burst;
        int n;
        logic [CFG_DATA_W-1:0] x_data;
        logic [CFG_DATA_W-1:0] y_data;
        logic [CFG_DATA_W-1:0] start_data;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            x_data = random_step_data();
            y_data = random_step_data();
            case ($urandom_range(0, 3))
                0: start_data = 24'h000000;
                1: start_data = 24'hFFFFFF;
                default: start_data = CFG_DATA_W'($urandom);
            endcase
            if (phase == 0) begin
                x_data = 24'd1;
                y_data = 24'd1;
                start_data = 24'd0;
            end else if (phase == 1) begin
                x_data = 24'hFFFFFF;
                y_data = 24'hFFFFFF;
                start_data = 24'hFFFFFF;
            end
            configure(x_data, y_data, start_data, 1'($urandom_range(0, 1)));
            sent = 0;
            while (sent < PHASE_REQUESTS) begin
                burst = $urandom_range(1, 24);
                for (n = 0; n < burst && sent < PHASE_REQUESTS; n++) begin
                    send_request(random_request());
                    sent++;
                end
                case ($urandom_range(0, 9))
                    0: wait_for_results();
                    1, 2, 3: ;
                    default: idle_sender($urandom_range(1, 6));
                endcase
            end
        end
    endtask

    // Output side stalls on its own changing pattern, plus the long hold-off.
    always @(posedge i_clk) begin
        ready_phase <= ready_phase + 3'd1;
        if (hold_off_seq != hold_off_seen) begin
            hold_off_seen <= hold_off_seq;
            hold_off_left <= HOLD_OFF_CYCLES;
            i_out_ready   <= 1'b0;
        end else if (hold_off_left != 0) begin
            hold_off_left <= hold_off_left - 1;
            i_out_ready   <= 1'b0;
        end else begin
            if (ready_run == 0) begin
                ready_mode <= t_ready_mode'($urandom_range(0, 4));
                ready_run  <= $urandom_range(20, 120);
            end else begin
                ready_run <= ready_run - 1;
            end
            case (ready_mode)
                READY_ALWAYS:   i_out_ready <= 1'b1;
                READY_HALF:     i_out_ready <= 1'($urandom_range(0, 1));
                READY_MOSTLY:   i_out_ready <= ($urandom_range(0, 7) != 0);
                READY_PERIODIC: i_out_ready <= (ready_phase < 3'd5);
                default:        i_out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_pixels.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, expected none actual %h",
                         $time, o_output_pixels);
            end else begin
                want_pixels = pending_pixels.pop_front();
                if (o_output_pixels !== want_pixels) begin
                    error_count++;
                    $display("%0t: output_pixels mismatch, expected %h actual %h",
                             $time, want_pixels, o_output_pixels);
                end
            end
        end
    end

    // Ends the run if no request of any kind moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("tb_top failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_fraction_extremes();
        test_register_index();
        test_backpressure();
        test_random_phases();
        wait_for_results();
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
